@@ rtl/prim_asm_pkg.sv @@
// ----------------------------------------------------------------------------
// Primitive assembler package
// Mode codes, field widths and result queue sizing shared by the block.
// ----------------------------------------------------------------------------
package prim_asm_pkg;

  localparam int FIELD_W         = 32;
  localparam int INDEX_W_DEFAULT = 32;
  localparam int MODE_W          = 3;
  localparam int COUNT_W         = 2;

  // Result queue: one input item can push up to two results.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_POINTS     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINES      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LINE_STRIP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LINE_LOOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIANGLES  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TRI_STRIP  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TRI_FAN    = 3'd6;

  localparam logic [COUNT_W-1:0] VCNT_POINT = 2'd1;
  localparam logic [COUNT_W-1:0] VCNT_LINE  = 2'd2;
  localparam logic [COUNT_W-1:0] VCNT_TRI   = 2'd3;

endpackage

@@ rtl/primitive_assembler_top.sv @@
// ----------------------------------------------------------------------------
// Primitive assembler top level
// Groups a stream of vertex indices into points, lines and triangles.
// ----------------------------------------------------------------------------
// Each accepted item carries one vertex index and a flag for the final index
// of a draw. The block takes one item per clock while in_stall is low: the
// assembly decision for an item is made in the cycle it is accepted, from the
// item and the kept state (first index of the draw, two kept slots, strip
// parity and a saturating vertex count), and the resulting primitives are
// pushed into a four-entry result queue. An item is accepted while the queue
// has room for two results, so with the result side draining every cycle the
// block sustains one item per cycle; the line loop close on the final index
// pushes two results. Results pass through the queue registers before they
// reach the output. Write primitive_mode only while the block is idle.
// Modes: points, line list, line strip, line loop, triangle
// list, triangle strip (odd triangles swap the first two indices) and triangle
// fan. Incomplete trailing groups are dropped; all kept state clears after the
// final index of a draw. Only the low INDEX_WIDTH bits of an index are used,
// and result indices are zero-extended.
// ----------------------------------------------------------------------------
module primitive_assembler_top #(
  parameter int INDEX_WIDTH = prim_asm_pkg::INDEX_W_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [prim_asm_pkg::MODE_W-1:0]    cfg_primitive_mode,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [prim_asm_pkg::FIELD_W-1:0]   in_vertex_index,
  input  logic                               in_last_in_draw,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [prim_asm_pkg::FIELD_W-1:0]   out_index_a,
  output logic [prim_asm_pkg::FIELD_W-1:0]   out_index_b,
  output logic [prim_asm_pkg::FIELD_W-1:0]   out_index_c,
  output logic [prim_asm_pkg::COUNT_W-1:0]   out_vertex_count,
  output logic                               out_last_result
);
  import prim_asm_pkg::*;

  localparam int IW = INDEX_WIDTH;

  // Configuration and kept draw state
  logic [MODE_W-1:0]  mode_r;
  logic [IW-1:0]      first_r, first_nxt;
  logic [IW-1:0]      slot0_r, slot0_nxt;
  logic [IW-1:0]      slot1_r, slot1_nxt;
  logic               parity_r, parity_nxt;
  logic [1:0]         seen_r, seen_nxt;

  // Result queue
  logic [IW-1:0]      q_a_r   [QUEUE_DEPTH];
  logic [IW-1:0]      q_b_r   [QUEUE_DEPTH];
  logic [IW-1:0]      q_c_r   [QUEUE_DEPTH];
  logic [COUNT_W-1:0] q_cnt_r [QUEUE_DEPTH];
  logic               q_last_r[QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  // Results generated by the current item
  logic               in_acc, out_acc;
  logic [IW-1:0]      v;
  logic [1:0]         seen_inc;
  logic               gen0, gen1;
  logic [IW-1:0]      p0_a, p0_b, p0_c, p1_a;
  logic [COUNT_W-1:0] p0_cnt;
  logic [1:0]         n_push;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign v       = IW'(in_vertex_index);

  // Hold off input unless two free queue entries remain.
  assign in_stall = (count_r > QCNT_W'(QUEUE_DEPTH - 2));

  assign seen_inc = (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;

  always_comb begin
    first_nxt  = first_r;
    slot0_nxt  = slot0_r;
    slot1_nxt  = slot1_r;
    parity_nxt = parity_r;
    seen_nxt   = seen_r;
    gen0       = 1'b0;
    gen1       = 1'b0;
    p0_a       = '0;
    p0_b       = '0;
    p0_c       = '0;
    p0_cnt     = VCNT_POINT;
    p1_a       = v;
    unique case (mode_r)
      MODE_POINTS: begin
        gen0 = 1'b1;
        p0_a = v;
      end
      MODE_LINES: begin
        if (seen_r == 2'd0) begin
          slot0_nxt = v;
          seen_nxt  = 2'd1;
        end else begin
          gen0     = 1'b1;
          p0_a     = slot0_r;
          p0_b     = v;
          p0_cnt   = VCNT_LINE;
          seen_nxt = 2'd0;
        end
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (seen_r == 2'd0) begin
          first_nxt = v;
        end else begin
          gen0   = 1'b1;
          p0_a   = slot0_r;
          p0_b   = v;
          p0_cnt = VCNT_LINE;
        end
        slot0_nxt = v;
        seen_nxt  = seen_inc;
        // close the loop back to the first index of the draw
        gen1 = (mode_r == MODE_LINE_LOOP) && in_last_in_draw && (seen_r != 2'd0);
      end
      MODE_TRIANGLES: begin
        if (seen_r == 2'd0) begin
          slot0_nxt = v;
          seen_nxt  = 2'd1;
        end else if (seen_r == 2'd1) begin
          slot1_nxt = v;
          seen_nxt  = 2'd2;
        end else begin
          gen0     = 1'b1;
          p0_a     = slot0_r;
          p0_b     = slot1_r;
          p0_c     = v;
          p0_cnt   = VCNT_TRI;
          seen_nxt = 2'd0;
        end
      end
      MODE_TRI_STRIP: begin
        if (seen_r == 2'd0) begin
          slot0_nxt = v;
        end else if (seen_r == 2'd1) begin
          slot1_nxt = v;
        end else begin
          gen0       = 1'b1;
          p0_a       = parity_r ? slot1_r : slot0_r;
          p0_b       = parity_r ? slot0_r : slot1_r;
          p0_c       = v;
          p0_cnt     = VCNT_TRI;
          slot0_nxt  = slot1_r;
          slot1_nxt  = v;
          parity_nxt = !parity_r;
        end
        seen_nxt = seen_inc;
      end
      MODE_TRI_FAN: begin
        if (seen_r == 2'd0) begin
          first_nxt = v;
        end else if (seen_r == 2'd1) begin
          slot1_nxt = v;
        end else begin
          gen0      = 1'b1;
          p0_a      = first_r;
          p0_b      = slot1_r;
          p0_c      = v;
          p0_cnt    = VCNT_TRI;
          slot1_nxt = v;
        end
        seen_nxt = seen_inc;
      end
      default: begin
        // unused mode code: emit nothing
      end
    endcase
    // drop all kept state after the final index
    if (in_last_in_draw) begin
      first_nxt  = '0;
      slot0_nxt  = '0;
      slot1_nxt  = '0;
      parity_nxt = 1'b0;
      seen_nxt   = 2'd0;
    end
  end

  assign n_push = {1'b0, gen0} + {1'b0, gen1};

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = count_nxt + QCNT_W'(n_push);
    end
    if (out_acc) begin
      count_nxt = count_nxt - QCNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_POINTS;
      first_r  <= '0;
      slot0_r  <= '0;
      slot1_r  <= '0;
      parity_r <= 1'b0;
      seen_r   <= 2'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_primitive_mode;
      end
      if (in_acc) begin
        first_r  <= first_nxt;
        slot0_r  <= slot0_nxt;
        slot1_r  <= slot1_nxt;
        parity_r <= parity_nxt;
        seen_r   <= seen_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Queue storage: the main primitive goes first, the loop close after it.
  always_ff @(posedge clk) begin
    if (in_acc && gen0) begin
      q_a_r[wr_ptr_r]    <= p0_a;
      q_b_r[wr_ptr_r]    <= p0_b;
      q_c_r[wr_ptr_r]    <= p0_c;
      q_cnt_r[wr_ptr_r]  <= p0_cnt;
      q_last_r[wr_ptr_r] <= !gen1;
    end
    if (in_acc && gen1) begin
      q_a_r[wr_ptr_r + QPTR_W'(gen0)]    <= p1_a;
      q_b_r[wr_ptr_r + QPTR_W'(gen0)]    <= first_r;
      q_c_r[wr_ptr_r + QPTR_W'(gen0)]    <= '0;
      q_cnt_r[wr_ptr_r + QPTR_W'(gen0)]  <= VCNT_LINE;
      q_last_r[wr_ptr_r + QPTR_W'(gen0)] <= 1'b1;
    end
  end

  assign out_valid        = (count_r != '0);
  assign out_index_a      = FIELD_W'(q_a_r[rd_ptr_r]);
  assign out_index_b      = FIELD_W'(q_b_r[rd_ptr_r]);
  assign out_index_c      = FIELD_W'(q_c_r[rd_ptr_r]);
  assign out_vertex_count = q_cnt_r[rd_ptr_r];
  assign out_last_result  = q_last_r[rd_ptr_r];

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count exceeds depth");

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (count_r <= QCNT_W'(QUEUE_DEPTH - 2)))
    else $error("item accepted without room for two results");

  a_draw_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_in_draw) |=> (seen_r == 2'd0 && !parity_r))
    else $error("draw state not cleared after final index");

  a_close_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && gen1) |-> gen0)
    else $error("loop close without the segment before it");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && count_r == QCNT_W'(1) && !in_acc) |=> !out_valid)
    else $error("result shown after queue drained");

endmodule

@@ tb/primitive_assembler_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Primitive assembler testbench
// Drives vertex index streams through every primitive mode, including mode
// changes in the middle of a draw and long output stalls. A built-in
// primitive predictor works out each expected primitive, and every result is
// checked against it in order.
// ----------------------------------------------------------------------------
module primitive_assembler_top_tb;
  import prim_asm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int IDX_W          = INDEX_W_DEFAULT;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [FIELD_W-1:0] IDX_MASK = {FIELD_W{1'b1}} >> (FIELD_W - IDX_W);

  // one assembled primitive as it leaves the block
  typedef struct {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
    logic [COUNT_W-1:0] count;
    logic               last;
  } prim_t;

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               cfg_we             = 1'b0;
  logic [MODE_W-1:0]  cfg_primitive_mode = '0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] in_vertex_index    = '0;
  logic               in_last_in_draw    = 1'b0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic [FIELD_W-1:0] out_index_a;
  logic [FIELD_W-1:0] out_index_b;
  logic [FIELD_W-1:0] out_index_c;
  logic [COUNT_W-1:0] out_vertex_count;
  logic               out_last_result;

  primitive_assembler_top #(
    .INDEX_WIDTH(IDX_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_primitive_mode(cfg_primitive_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_vertex_index   (in_vertex_index),
    .in_last_in_draw   (in_last_in_draw),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_vertex_count  (out_vertex_count),
    .out_last_result   (out_last_result)
  );

  // Predictor copy of the assembly state.
  logic [MODE_W-1:0]  asm_mode;
  logic [FIELD_W-1:0] draw_pivot;
  logic [FIELD_W-1:0] keep_old;
  logic [FIELD_W-1:0] keep_new;
  logic               strip_odd;
  logic [1:0]         seen_cnt;

  // Primitives still owed by the block, oldest first.
  prim_t pending_prims[$];

  int errors         = 0;
  int items_accepted = 0;
  int prims_checked  = 0;
  int mode_writes    = 0;

  // Traffic shaping shared between the stimulus and the result side.
  bit calm        = 1'b0;
  int hold_token  = 0;
  int hold_seen   = 0;
  int stall_left  = 0;
  int rx_quiet    = 0;
  int tx_quiet    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Primitive predictor
  // --------------------------------------------------------------------------
  function automatic prim_t make_prim(input logic [FIELD_W-1:0] a,
                                      input logic [FIELD_W-1:0] b,
                                      input logic [FIELD_W-1:0] c,
                                      input logic [COUNT_W-1:0] count);
    prim_t p;
    p.a     = a;
    p.b     = b;
    p.c     = c;
    p.count = count;
    p.last  = 1'b0;
    return p;
  endfunction

  // Advance the predictor by one accepted index and queue what it produces.
  function automatic void assemble_vertex(input logic [FIELD_W-1:0] raw,
                                          input logic last);
    prim_t              made [2];
    int                 n;
    logic [FIELD_W-1:0] v;
    n = 0;
    v = raw & IDX_MASK;
    case (asm_mode)
      MODE_POINTS: begin
        made[n] = make_prim(v, '0, '0, VCNT_POINT);
        n++;
      end
      MODE_LINES: begin
        // any nonzero count left by another mode counts as the first vertex
        if (seen_cnt == 2'd0) begin
          keep_old = v;
          seen_cnt = 2'd1;
        end else begin
          made[n] = make_prim(keep_old, v, '0, VCNT_LINE);
          n++;
          seen_cnt = 2'd0;
        end
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (seen_cnt == 2'd0) begin
          draw_pivot = v;
        end else begin
          made[n] = make_prim(keep_old, v, '0, VCNT_LINE);
          n++;
        end
        keep_old = v;
        if (seen_cnt != 2'd3) seen_cnt++;
        // close the loop back to the first index once two were seen
        if (asm_mode == MODE_LINE_LOOP && last && seen_cnt >= 2'd2) begin
          made[n] = make_prim(v, draw_pivot, '0, VCNT_LINE);
          n++;
        end
      end
      MODE_TRIANGLES: begin
        if (seen_cnt == 2'd0) begin
          keep_old = v;
          seen_cnt = 2'd1;
        end else if (seen_cnt == 2'd1) begin
          keep_new = v;
          seen_cnt = 2'd2;
        end else begin
          made[n] = make_prim(keep_old, keep_new, v, VCNT_TRI);
          n++;
          seen_cnt = 2'd0;
        end
      end
      MODE_TRI_STRIP: begin
        if (seen_cnt == 2'd0) begin
          keep_old = v;
        end else if (seen_cnt == 2'd1) begin
          keep_new = v;
        end else begin
          // odd triangles swap the two kept indices to keep the winding
          if (strip_odd) made[n] = make_prim(keep_new, keep_old, v, VCNT_TRI);
          else           made[n] = make_prim(keep_old, keep_new, v, VCNT_TRI);
          n++;
          keep_old  = keep_new;
          keep_new  = v;
          strip_odd = ~strip_odd;
        end
        if (seen_cnt != 2'd3) seen_cnt++;
      end
      MODE_TRI_FAN: begin
        if (seen_cnt == 2'd0) begin
          draw_pivot = v;
        end else if (seen_cnt == 2'd1) begin
          keep_new = v;
        end else begin
          made[n] = make_prim(draw_pivot, keep_new, v, VCNT_TRI);
          n++;
          keep_new = v;
        end
        if (seen_cnt != 2'd3) seen_cnt++;
      end
      default: ;  // unused mode: nothing assembled
    endcase

    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_prims = {pending_prims, made[i]};

    // a draw's final index clears everything kept
    if (last) begin
      draw_pivot = '0;
      keep_old   = '0;
      keep_new   = '0;
      strip_odd  = 1'b0;
      seen_cnt   = 2'd0;
    end
  endfunction

  function automatic void clear_predictor();
    asm_mode   = MODE_POINTS;
    draw_pivot = '0;
    keep_old   = '0;
    keep_new   = '0;
    strip_odd  = 1'b0;
    seen_cnt   = 2'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted primitive and shape out_stall
  // --------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_prim();
    prim_t want;
    if (pending_prims.size() == 0) begin
      errors++;
      $display("%0t: unexpected primitive, expected none, got %h %h %h count %0d",
               $time, out_index_a, out_index_b, out_index_c, out_vertex_count);
    end else begin
      want = pending_prims.pop_front();
      prims_checked++;
      report_field("index_a", want.a, out_index_a);
      report_field("index_b", want.b, out_index_b);
      report_field("index_c", want.c, out_index_c);
      report_field("vertex_count", FIELD_W'(want.count), FIELD_W'(out_vertex_count));
      report_field("last_result", FIELD_W'(want.last), FIELD_W'(out_last_result));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_prim();

    // A new hold request overrides everything: stall for a long stretch so
    // the result queue fills up and the block has to stall its input.
    if (hold_token != hold_seen) begin
      hold_seen  = hold_token;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (rx_quiet > 0) begin
      rx_quiet--;
    end else if (!calm) begin
      case ($urandom_range(0, 15))
        0, 1:    stall_left = $urandom_range(1, 12);
        2:       rx_quiet   = $urandom_range(20, 60);
        default: ;
      endcase
    end
    out_stall <= (stall_left > 0);
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no item moved for %0d cycles, %0d primitives still owed",
             $time, WATCHDOG_LIMIT, pending_prims.size());
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one index and hold it until the block takes it. Valid stays high
  // after acceptance so back-to-back items need no extra assignment.
  task automatic send_item(input logic [FIELD_W-1:0] idx, input logic last);
    if (tx_quiet > 0) begin
      tx_quiet--;
    end else if (!calm) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        2:       tx_quiet = $urandom_range(20, 60);
        default: ;
      endcase
    end
    in_valid        <= 1'b1;
    in_vertex_index <= idx;
    in_last_in_draw <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_accepted++;
    assemble_vertex(idx, last);
  endtask

  // Drop valid and wait until every owed primitive has come out, then give
  // the block time to settle after any item that produced nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_prims.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    wait_idle();
    cfg_we             <= 1'b1;
    cfg_primitive_mode <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    asm_mode = mode;
    mode_writes++;
  endtask

  function automatic logic [FIELD_W-1:0] rand_index();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_W'($urandom_range(0, 15));
      3:       return {{(FIELD_W-4){1'b1}}, 4'($urandom_range(0, 15))};
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // One short draw per mode with extreme indices, dropped trailing groups,
  // a single-index loop (no close), a full loop close and the unused mode.
  task automatic test_each_mode();
    write_mode(MODE_POINTS);
    send_item('0, 1'b0);
    send_item('1, 1'b1);
    write_mode(MODE_LINES);
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);
    write_mode(MODE_LINE_STRIP);
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd3, 1'b1);
    write_mode(MODE_LINE_LOOP);
    send_item(32'd5, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'd8, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    write_mode(MODE_TRIANGLES);
    send_item(32'd10, 1'b0);
    send_item(32'd11, 1'b0);
    send_item(32'd12, 1'b0);
    send_item(32'd13, 1'b1);
    write_mode(MODE_TRI_STRIP);
    for (int i = 20; i < 25; i++) send_item(i, i == 24);
    write_mode(MODE_TRI_FAN);
    for (int i = 30; i < 34; i++) send_item(i, i == 33);
    write_mode(MODE_UNUSED);
    send_item(32'd40, 1'b0);
    send_item(32'd41, 1'b1);
  endtask

  // Change mode with a draw still open: the new mode inherits the kept state.
  task automatic test_mode_switch_mid_draw();
    write_mode(MODE_TRI_STRIP);
    send_item(32'd50, 1'b0);
    send_item(32'd51, 1'b0);
    send_item(32'd52, 1'b0);
    write_mode(MODE_LINES);
    send_item(32'd53, 1'b0);
    write_mode(MODE_TRIANGLES);
    send_item(32'd54, 1'b0);
    send_item(32'd55, 1'b0);
    write_mode(MODE_TRI_FAN);
    send_item(32'd56, 1'b1);
  endtask

  // Hold the result side off while the sender keeps offering, then pause
  // the sender until every owed primitive has drained.
  task automatic test_output_backlog();
    write_mode(MODE_POINTS);
    hold_token <= hold_token + 1;
    for (int i = 0; i < 30; i++) send_item(rand_index(), i == 29);
    wait_idle();
    write_mode(MODE_LINE_LOOP);
    hold_token <= hold_token + 1;
    for (int i = 0; i < 24; i++) send_item(rand_index(), (i % 3) == 2);
    wait_idle();
  endtask

  // Phases of random draws in random modes. A phase can end with its last
  // draw still open, so the next mode picks up leftover state.
  task automatic test_random_draws(input int target);
    int                counted;
    int                phase_len;
    int                draw_len;
    int                k;
    logic [MODE_W-1:0] mode;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(0, 19) == 0) mode = MODE_UNUSED;
      else mode = MODE_W'($urandom_range(0, 6));
      write_mode(mode);
      phase_len = $urandom_range(20, 80);
      k = 0;
      while (k < phase_len) begin
        draw_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                               : $urandom_range(1, 8);
        for (int i = 0; i < draw_len && k < phase_len; i++) begin
          send_item(rand_index(), i == draw_len - 1);
          k++;
        end
      end
      if (mode != MODE_UNUSED) counted += phase_len;
    end
  endtask

  // Full-rate stream with no random idling on either side.
  task automatic test_steady_stream();
    calm = 1'b1;
    write_mode(MODE_LINE_LOOP);
    for (int i = 0; i < 60; i++) send_item(rand_index(), ($urandom_range(0, 5) == 0));
    write_mode(MODE_TRI_STRIP);
    for (int i = 0; i < 60; i++) send_item(rand_index(), ($urandom_range(0, 9) == 0));
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_each_mode();
    test_mode_switch_mid_draw();
    test_output_backlog();
    test_random_draws(1370);
    test_steady_stream();

    // drain and leave room for any stray primitive to show up
    wait_idle();
    repeat (8) @(posedge clk);

    $display("tb: %0d indices accepted, %0d primitives checked, %0d mode writes",
             items_accepted, prims_checked, mode_writes);
    $display("tb: all modes, mid-draw mode changes, long output stalls, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
